>>> sv/icp_pkg.sv
// shared types, constants and character helpers for the infix to prefix converter
package icp_pkg;

    // store depth and derived widths
    localparam int MAX_CHARS = 64;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int ADDR_W    = $clog2(MAX_CHARS);

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNBALANCE = 2'd1,
        STAT_TOO_LONG  = 2'd2
    } t_status;

    // conversion sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CLASS,
        ST_TOP,
        ST_FLUSH,
        ST_FLUSH_POP,
        ST_EMIT_START,
        ST_EMIT
    } t_state;

    // one input transfer
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       out_last;
        t_status    status;
    } t_out_item;

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    // precedence: 1 for + and -, 2 for * and /, 0 otherwise
    function automatic logic [1:0] rank(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd0;
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            r = 2'd1;
        end else if ((c == CH_STAR) || (c == CH_SLASH)) begin
            r = 2'd2;
        end
        return r;
    endfunction

endpackage

>>> sv/icp_ram.sv
// simple dual port synchronous ram with registered, enable-held read data
module icp_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/infix_to_prefix_converter_unit.sv
// top level of the infix to prefix converter: input store, operator stack and output store
// Characters are taken one per cycle while o_busy is low; a character transfer without
// in_last gives no result. The transfer with in_last raises o_busy for the conversion: the
// backward scan takes a store read, then a classify step, per stored character, every
// stack top compare or pop adds an ST_TOP step, every operator left on the stack at the end is
// read, then popped, and the prefix string then leaves at one result per cycle, the last
// one flagged out_last. All three stores are synchronous memories with registered read
// data and one read port each. An expression that overflows the store returns a
// single too-long result in the cycle after its last character, without raising o_busy.
// Results are shown for one cycle with o_strobe and cannot be held off by the receiver. No
// clearing pass runs after reset.
module infix_to_prefix_converter_unit
    import icp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_in,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_out
);

    // control registers
    t_state           r_state,     n_state;
    logic [CNT_W-1:0] r_expr_cnt,  n_expr_cnt;
    logic             r_ovf,       n_ovf;
    logic [CNT_W-1:0] r_depth,     n_depth;
    logic [CNT_W-1:0] r_out_cnt,   n_out_cnt;
    logic [CNT_W-1:0] r_idx,       n_idx;
    logic             r_strobe,    n_strobe;
    // payload registers
    logic [7:0]       r_ch,        n_ch;
    t_out_item        r_out,       n_out;

    // memory ports
    logic              expr_we,  expr_re;
    logic [ADDR_W-1:0] expr_waddr, expr_raddr;
    logic [7:0]        expr_wdata, expr_rdata;
    logic              stk_we,   stk_re;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;
    logic [7:0]        stk_wdata, stk_rdata;
    logic              outs_we,  outs_re;
    logic [ADDR_W-1:0] outs_waddr, outs_raddr;
    logic [7:0]        outs_wdata, outs_rdata;

    // decremented counters
    logic [CNT_W-1:0] idx_m1, depth_m1, depth_m2, out_m1;
    assign idx_m1   = r_idx - 1'b1;
    assign depth_m1 = r_depth - 1'b1;
    assign depth_m2 = r_depth - CNT_W'(2);
    assign out_m1   = r_out_cnt - 1'b1;

    icp_ram #(.DEPTH(MAX_CHARS), .WIDTH(8)) u_expr_ram (
        .i_clk   (i_clk),
        .i_we    (expr_we),
        .i_waddr (expr_waddr),
        .i_wdata (expr_wdata),
        .i_re    (expr_re),
        .i_raddr (expr_raddr),
        .o_rdata (expr_rdata)
    );

    icp_ram #(.DEPTH(MAX_CHARS), .WIDTH(8)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    icp_ram #(.DEPTH(MAX_CHARS), .WIDTH(8)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (outs_we),
        .i_waddr (outs_waddr),
        .i_wdata (outs_wdata),
        .i_re    (outs_re),
        .i_raddr (outs_raddr),
        .o_rdata (outs_rdata)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_expr_cnt <= '0;
            r_ovf      <= 1'b0;
            r_depth    <= '0;
            r_out_cnt  <= '0;
            r_idx      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_expr_cnt <= n_expr_cnt;
            r_ovf      <= n_ovf;
            r_depth    <= n_depth;
            r_out_cnt  <= n_out_cnt;
            r_idx      <= n_idx;
            r_strobe   <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ch  <= n_ch;
        r_out <= n_out;
    end

    // sequencer: next state, memory accesses and results
    always_comb begin
        logic       put;
        logic [7:0] put_data;
        logic       finish;

        put        = 1'b0;
        put_data   = '0;
        finish     = 1'b0;

        n_state    = r_state;
        n_expr_cnt = r_expr_cnt;
        n_ovf      = r_ovf;
        n_depth    = r_depth;
        n_out_cnt  = r_out_cnt;
        n_idx      = r_idx;
        n_strobe   = 1'b0;
        n_ch       = r_ch;
        n_out      = r_out;

        expr_we    = 1'b0;
        expr_waddr = r_expr_cnt[ADDR_W-1:0];
        expr_wdata = i_in.in_char;
        expr_re    = 1'b0;
        expr_raddr = idx_m1[ADDR_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_depth[ADDR_W-1:0];
        stk_wdata  = r_ch;
        stk_re     = 1'b0;
        stk_raddr  = depth_m1[ADDR_W-1:0];
        outs_re    = 1'b0;
        outs_raddr = out_m1[ADDR_W-1:0];

        case (r_state)
            // load characters, start the scan on the last one
            ST_IDLE: begin
                if (i_start) begin
                    if (r_expr_cnt < CNT_W'(MAX_CHARS)) begin
                        expr_we    = 1'b1;
                        n_expr_cnt = r_expr_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.in_last) begin
                        if (r_ovf || (r_expr_cnt == CNT_W'(MAX_CHARS))) begin
                            n_strobe       = 1'b1;
                            n_out.out_char = '0;
                            n_out.has_char = 1'b0;
                            n_out.out_last = 1'b1;
                            n_out.status   = STAT_TOO_LONG;
                            finish         = 1'b1;
                        end else begin
                            n_idx   = r_expr_cnt + 1'b1;
                            n_state = ST_FETCH;
                        end
                    end
                end
            end

            // read the next stored character, going backward
            ST_FETCH: begin
                if (r_idx == '0) begin
                    n_state = ST_FLUSH;
                end else begin
                    expr_re = 1'b1;
                    n_idx   = idx_m1;
                    n_state = ST_CLASS;
                end
            end

            // classify the character just read
            ST_CLASS: begin
                n_ch    = expr_rdata;
                n_state = ST_FETCH;
                if (is_alnum(expr_rdata)) begin
                    put      = 1'b1;
                    put_data = expr_rdata;
                end else if (expr_rdata == CH_RPAR) begin
                    if (r_depth < CNT_W'(MAX_CHARS)) begin
                        stk_we    = 1'b1;
                        stk_wdata = expr_rdata;
                        n_depth   = r_depth + 1'b1;
                    end
                end else if ((expr_rdata == CH_LPAR) || is_op(expr_rdata)) begin
                    if (r_depth != '0) begin
                        stk_re  = 1'b1;
                        n_state = ST_TOP;
                    end else if (expr_rdata == CH_LPAR) begin
                        // stray open parenthesis
                        n_strobe       = 1'b1;
                        n_out.out_char = '0;
                        n_out.has_char = 1'b0;
                        n_out.out_last = 1'b1;
                        n_out.status   = STAT_UNBALANCE;
                        finish         = 1'b1;
                    end else begin
                        stk_we    = 1'b1;
                        stk_wdata = expr_rdata;
                        n_depth   = r_depth + 1'b1;
                    end
                end
            end

            // compare against the stack top, pop or push
            ST_TOP: begin
                if (r_ch == CH_LPAR) begin
                    if (stk_rdata == CH_RPAR) begin
                        n_depth = depth_m1;
                        n_state = ST_FETCH;
                    end else begin
                        put      = 1'b1;
                        put_data = stk_rdata;
                        n_depth  = depth_m1;
                        if (depth_m1 == '0) begin
                            n_strobe       = 1'b1;
                            n_out.out_char = '0;
                            n_out.has_char = 1'b0;
                            n_out.out_last = 1'b1;
                            n_out.status   = STAT_UNBALANCE;
                            finish         = 1'b1;
                        end else begin
                            stk_re    = 1'b1;
                            stk_raddr = depth_m2[ADDR_W-1:0];
                        end
                    end
                end else if (rank(r_ch) < rank(stk_rdata)) begin
                    put      = 1'b1;
                    put_data = stk_rdata;
                    if (depth_m1 == '0) begin
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        n_depth   = CNT_W'(1);
                        n_state   = ST_FETCH;
                    end else begin
                        n_depth   = depth_m1;
                        stk_re    = 1'b1;
                        stk_raddr = depth_m2[ADDR_W-1:0];
                    end
                end else begin
                    if (r_depth < CNT_W'(MAX_CHARS)) begin
                        stk_we  = 1'b1;
                        n_depth = r_depth + 1'b1;
                    end
                    n_state = ST_FETCH;
                end
            end

            // empty the stack into the output store
            ST_FLUSH: begin
                if (r_depth == '0) begin
                    n_state = ST_EMIT_START;
                end else begin
                    stk_re  = 1'b1;
                    n_state = ST_FLUSH_POP;
                end
            end

            ST_FLUSH_POP: begin
                put      = 1'b1;
                put_data = stk_rdata;
                n_depth  = depth_m1;
                n_state  = ST_FLUSH;
            end

            // first read of the reversed output, or the empty result
            ST_EMIT_START: begin
                if (r_out_cnt == '0) begin
                    n_strobe       = 1'b1;
                    n_out.out_char = '0;
                    n_out.has_char = 1'b0;
                    n_out.out_last = 1'b1;
                    n_out.status   = STAT_OK;
                    finish         = 1'b1;
                end else begin
                    outs_re   = 1'b1;
                    n_out_cnt = out_m1;
                    n_state   = ST_EMIT;
                end
            end

            // one result per cycle, next read overlapped
            ST_EMIT: begin
                n_strobe       = 1'b1;
                n_out.out_char = outs_rdata;
                n_out.has_char = 1'b1;
                n_out.out_last = (r_out_cnt == '0);
                n_out.status   = STAT_OK;
                if (r_out_cnt == '0) begin
                    finish = 1'b1;
                end else begin
                    outs_re   = 1'b1;
                    n_out_cnt = out_m1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output store append, dropped once full
        outs_we    = 1'b0;
        outs_waddr = r_out_cnt[ADDR_W-1:0];
        outs_wdata = put_data;
        if (put && (r_out_cnt < CNT_W'(MAX_CHARS))) begin
            outs_we   = 1'b1;
            n_out_cnt = r_out_cnt + 1'b1;
        end

        // expression done: counts and flags back to zero
        if (finish) begin
            n_state    = ST_IDLE;
            n_expr_cnt = '0;
            n_ovf      = 1'b0;
            n_depth    = '0;
            n_out_cnt  = '0;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // a result without a character always closes the expression
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.has_char) |-> o_out.out_last)
        else $error("result without character not marked last");

    // an error status never carries a character
    a_err_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_out.status != STAT_OK)) |-> !o_out.has_char)
        else $error("error result carries a character");

    // every emit cycle produces a result transfer
    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |=> o_strobe)
        else $error("emit cycle without result");

    // stack and output counts stay within the stores
    a_counts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth <= CNT_W'(MAX_CHARS)) && (r_out_cnt <= CNT_W'(MAX_CHARS)))
        else $error("stack or output count beyond store depth");

endmodule
